### rtl/core/point_in_polygon_test_top_defines.svh
// ----------------------------------------------------------------------------
// Point-in-polygon test: assertion macros
// Concurrent assertion shorthands clocked on clk_i, disabled during reset.
// ----------------------------------------------------------------------------
`ifndef POINT_IN_POLYGON_TEST_TOP_DEFINES_SVH
`define POINT_IN_POLYGON_TEST_TOP_DEFINES_SVH

// Same-cycle implication.
`define PIP_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("point_in_polygon_test: assertion failed");

// Next-cycle implication.
`define PIP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("point_in_polygon_test: assertion failed");

`endif

### rtl/core/pip_pkg.sv
// ----------------------------------------------------------------------------
// Point-in-polygon test package
// Sizes, opcodes and shared types of the polygon tester.
// ----------------------------------------------------------------------------
package pip_pkg;

  localparam int MAX_VERTICES = 256;
  localparam int COORD_WIDTH  = 16;
  localparam int ADDR_W       = $clog2(MAX_VERTICES);
  localparam int CNT_W        = 9;
  localparam int IDX_W        = 8;
  localparam int DIFF_W       = COORD_WIDTH + 1;
  localparam int PROD_W       = 2 * DIFF_W;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] x;
    logic signed [COORD_WIDTH-1:0] y;
  } pip_vertex_t;

  typedef struct packed {
    logic start;
    logic load_prev;
    logic diff;
    logic mul_first;
    logic mul_second;
    logic compare;
  } pip_edge_ctl_t;

endpackage

### rtl/core/pip_req_if.sv
// ----------------------------------------------------------------------------
// Point-in-polygon request channel
// Valid/ready channel carrying vertex writes and point queries.
// ----------------------------------------------------------------------------
interface pip_req_if import pip_pkg::*; ();
  logic                          valid;
  logic                          ready;
  logic                          opcode;
  logic [IDX_W-1:0]              vertex_index;
  logic signed [COORD_WIDTH-1:0] coord_x;
  logic signed [COORD_WIDTH-1:0] coord_y;

  modport source (output valid, opcode, vertex_index, coord_x, coord_y, input ready);
  modport sink   (input valid, opcode, vertex_index, coord_x, coord_y, output ready);
endinterface

### rtl/core/pip_rsp_if.sv
// ----------------------------------------------------------------------------
// Point-in-polygon response channel
// Valid/ready channel carrying the inside flag of a query.
// ----------------------------------------------------------------------------
interface pip_rsp_if ();
  logic valid;
  logic ready;
  logic inside_res;

  modport source (output valid, inside_res, input ready);
  modport sink   (input valid, inside_res, output ready);
endinterface

### rtl/core/pip_vstore.sv
// ----------------------------------------------------------------------------
// Point-in-polygon vertex store
// Single-port-write, registered-read memory of polygon vertices.
// ----------------------------------------------------------------------------
module pip_vstore import pip_pkg::*; (
  input  logic              clk_i,
  input  logic              wr_en_i,
  input  logic [ADDR_W-1:0] wr_addr_i,
  input  pip_vertex_t       wr_data_i,
  input  logic              rd_en_i,
  input  logic [ADDR_W-1:0] rd_addr_i,
  output pip_vertex_t       rd_data_o
);

  pip_vertex_t mem [MAX_VERTICES];
  pip_vertex_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

### rtl/core/pip_edge_unit.sv
// ----------------------------------------------------------------------------
// Point-in-polygon edge unit
// Shared difference, multiply and compare datapath for one edge at a time.
// ----------------------------------------------------------------------------
module pip_edge_unit import pip_pkg::*; (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  pip_edge_ctl_t                 ctl_i,
  input  logic signed [COORD_WIDTH-1:0] px_i,
  input  logic signed [COORD_WIDTH-1:0] py_i,
  input  pip_vertex_t                   cur_i,
  output logic                          inside_o
);

  logic signed [COORD_WIDTH-1:0] px_q, py_q;
  pip_vertex_t                   prev_q;
  logic signed [DIFF_W-1:0]      a_q, b_q, c_q, d_q;
  logic                          straddle_q;
  logic signed [PROD_W-1:0]      p1_q, p2_q;
  logic                          inside_q;
  logic signed [DIFF_W-1:0]      mul_x, mul_y;
  logic signed [PROD_W-1:0]      mul_p;
  logic                          straddle;
  logic                          left;

  assign straddle = ((cur_i.y < py_q) && (prev_q.y >= py_q)) ||
                    ((prev_q.y < py_q) && (cur_i.y >= py_q));

  assign mul_x = ctl_i.mul_second ? c_q : a_q;
  assign mul_y = ctl_i.mul_second ? d_q : b_q;
  assign mul_p = PROD_W'(mul_x) * PROD_W'(mul_y);

  assign left = d_q[DIFF_W-1] ? (p1_q > p2_q) : (p1_q < p2_q);

  always_ff @(posedge clk_i) begin
    if (ctl_i.start) begin
      px_q <= px_i;
      py_q <= py_i;
    end
    if (ctl_i.load_prev || ctl_i.diff) begin
      prev_q <= cur_i;
    end
    if (ctl_i.diff) begin
      a_q <= DIFF_W'(py_q) - DIFF_W'(cur_i.y);
      b_q <= DIFF_W'(prev_q.x) - DIFF_W'(cur_i.x);
      c_q <= DIFF_W'(px_q) - DIFF_W'(cur_i.x);
      d_q <= DIFF_W'(prev_q.y) - DIFF_W'(cur_i.y);
    end
    if (ctl_i.mul_first) begin
      p1_q <= mul_p;
    end
    if (ctl_i.mul_second) begin
      p2_q <= mul_p;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inside_q   <= 1'b0;
      straddle_q <= 1'b0;
    end else begin
      if (ctl_i.diff) begin
        straddle_q <= straddle;
      end
      if (ctl_i.start) begin
        inside_q <= 1'b0;
      end else if (ctl_i.compare && straddle_q && left) begin
        inside_q <= !inside_q;
      end
    end
  end

  assign inside_o = inside_q;

endmodule

### rtl/core/point_in_polygon_test_top.sv
// ----------------------------------------------------------------------------
// Point-in-polygon test top level
// Even-odd point-in-polygon tester with an on-chip vertex store.
// ----------------------------------------------------------------------------
// Usage:
//   req_i carries requests. opcode OP_WRITE stores (coord_x, coord_y) at
//   vertex_index and gives no response. opcode OP_QUERY tests
//   the point against the polygon of the first vertex_count stored vertices
//   and gives one response on rsp_o, the inside flag.
//   cfg_we_i/cfg_data_i write vertex_count; the user must do so only
//   while the block is idle, which the block does not enforce. Counts above
//   MAX_VERTICES saturate. A query first reads the last vertex in use as
//   the previous vertex; an empty polygon goes straight to the response. Each
//   edge then goes through one read of the vertex memory, a difference step,
//   two passes through the shared multiplier and a compare. Writes are taken
//   every cycle while the block is idle. The block accepts no request while
//   a query runs. Reset clears vertex_count and the response channel; the
//   vertex memory holds garbage until written. A stalled response stays in
//   its output register; the block still takes the next request meanwhile
//   and holds a finished query until the output register frees up.
// ----------------------------------------------------------------------------
module point_in_polygon_test_top import pip_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [CNT_W-1:0]  cfg_data_i,
  pip_req_if.sink           req_i,
  pip_rsp_if.source         rsp_o
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PRIME,
    ST_LOADP,
    ST_READ,
    ST_DIFF,
    ST_MUL1,
    ST_MUL2,
    ST_CMP,
    ST_DONE
  } state_e;

  state_e            state_q;
  logic [CNT_W-1:0]  count_q;
  logic [CNT_W-1:0]  n_q;
  logic [CNT_W-1:0]  i_q;
  logic              rsp_valid_q;
  logic              rsp_inside_q;

  logic              accept;
  logic              wr_en;
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic [CNT_W-1:0]  n_sat;
  pip_vertex_t       wr_data;
  pip_vertex_t       rd_data;
  pip_edge_ctl_t     ctl;
  logic              edge_inside;
  logic              out_free;

  assign req_i.ready = (state_q == ST_IDLE);
  assign accept      = req_i.valid && req_i.ready;
  assign wr_en       = accept && (req_i.opcode == OP_WRITE) &&
                       (32'(req_i.vertex_index) < MAX_VERTICES);
  assign wr_data.x   = req_i.coord_x;
  assign wr_data.y   = req_i.coord_y;
  assign n_sat       = (32'(count_q) > MAX_VERTICES) ? CNT_W'(MAX_VERTICES) : count_q;
  assign out_free    = !rsp_valid_q || rsp_o.ready;

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = ADDR_W'(i_q);
    unique case (state_q)
      ST_PRIME: begin
        rd_en   = 1'b1;
        rd_addr = ADDR_W'(n_q - CNT_W'(1));
      end
      ST_READ: rd_en = 1'b1;
      default: ;
    endcase
  end

  always_comb begin
    ctl            = '0;
    ctl.start      = accept && (req_i.opcode == OP_QUERY);
    ctl.load_prev  = (state_q == ST_LOADP);
    ctl.diff       = (state_q == ST_DIFF);
    ctl.mul_first  = (state_q == ST_MUL1);
    ctl.mul_second = (state_q == ST_MUL2);
    ctl.compare    = (state_q == ST_CMP);
  end

  pip_vstore u_vstore (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (ADDR_W'(req_i.vertex_index)),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  pip_edge_unit u_edge (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (ctl),
    .px_i     (req_i.coord_x),
    .py_i     (req_i.coord_y),
    .cur_i    (rd_data),
    .inside_o (edge_inside)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      count_q      <= '0;
      n_q          <= '0;
      i_q          <= '0;
      rsp_valid_q  <= 1'b0;
      rsp_inside_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        count_q <= cfg_data_i;
      end
      if ((state_q == ST_DONE) && out_free) begin
        rsp_valid_q  <= 1'b1;
        rsp_inside_q <= edge_inside;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (ctl.start) begin
            n_q     <= n_sat;
            i_q     <= '0;
            state_q <= (n_sat == '0) ? ST_DONE : ST_PRIME;
          end
        end
        ST_PRIME: state_q <= ST_LOADP;
        ST_LOADP: state_q <= ST_READ;
        ST_READ:  state_q <= ST_DIFF;
        ST_DIFF:  state_q <= ST_MUL1;
        ST_MUL1:  state_q <= ST_MUL2;
        ST_MUL2:  state_q <= ST_CMP;
        ST_CMP: begin
          if (i_q == n_q - CNT_W'(1)) begin
            state_q <= ST_DONE;
          end else begin
            i_q     <= i_q + CNT_W'(1);
            state_q <= ST_READ;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign rsp_o.valid      = rsp_valid_q;
  assign rsp_o.inside_res = rsp_inside_q;

endmodule

### rtl/core/pip_checker.sv
// ----------------------------------------------------------------------------
// Point-in-polygon port checker
// Port-level assertions on the polygon tester, bound to its top level.
// ----------------------------------------------------------------------------
`include "point_in_polygon_test_top_defines.svh"

module pip_checker import pip_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic req_valid_i,
  input logic req_ready_i,
  input logic req_opcode_i,
  input logic rsp_valid_i,
  input logic rsp_ready_i
);

  logic req_fire;

  assign req_fire = req_valid_i && req_ready_i;

  `PIP_ASSERT_NEXT(a_rsp_hold, rsp_valid_i && !rsp_ready_i, rsp_valid_i)
  `PIP_ASSERT_NEXT(a_query_busy, req_fire && (req_opcode_i == OP_QUERY), !req_ready_i)
  `PIP_ASSERT_NEXT(a_write_free, req_fire && (req_opcode_i == OP_WRITE), req_ready_i)
  `PIP_ASSERT_SAME(a_rsp_from_query, $rose(rsp_valid_i), $past(!req_ready_i))

endmodule

bind point_in_polygon_test_top pip_checker u_pip_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .req_valid_i  (req_i.valid),
  .req_ready_i  (req_i.ready),
  .req_opcode_i (req_i.opcode),
  .rsp_valid_i  (rsp_o.valid),
  .rsp_ready_i  (rsp_o.ready)
);
